[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a plain expression on every rising clock edge outside reset.
`define ASSERT_TRUE(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_TRUE(lbl, clk, rst, expr)

`endif

`endif

[hdl/hpk_pkg.sv]
package hpk_pkg;

  localparam int WORD_BITS       = 32;
  localparam int SYMBOLS_DEFAULT = 256;
  localparam int LEN_W           = 6;
  localparam int POS_W           = 5;
  localparam int BYTES_W         = 3;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [BYTES_W-1:0] FULL_BYTES = BYTES_W'(WORD_BITS / 8);

  typedef struct packed {
    logic [1:0]           req_type;
    logic [7:0]           symbol;
    logic [WORD_BITS-1:0] code_bits;
    logic [LEN_W-1:0]     code_length;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic [BYTES_W-1:0]   byte_count;
    logic                 last;
  } out_word_t;

  // Table read result handed from the lookup stage to the packer.
  typedef struct packed {
    logic                 valid;
    logic [1:0]           req_type;
    logic                 hit;
    logic [WORD_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
  } lookup_t;

  // Ones in the low n bits; n at or above the word width gives all ones.
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= LEN_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

[hdl/hpk_code_mem.sv]
module hpk_code_mem #(
  parameter int SYMBOLS = hpk_pkg::SYMBOLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hpk_pkg::in_word_t  in_data,
  input  logic               advance,
  output hpk_pkg::lookup_t   lookup
);

  localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ENTRY_W = hpk_pkg::WORD_BITS + hpk_pkg::LEN_W;

  logic [ENTRY_W-1:0] mem [SYMBOLS];
  logic [ENTRY_W-1:0] rd_data;

  logic                       valid;
  logic [1:0]                 req_type;
  logic                       hit;
  logic                       accept;
  logic                       in_range;
  logic [IDX_W-1:0]           idx;
  logic [hpk_pkg::LEN_W-1:0]  len_sat;
  logic [hpk_pkg::WORD_BITS-1:0] code_clean;

  assign in_stall = valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_data.symbol) < 32'(SYMBOLS));
  assign idx      = in_data.symbol[IDX_W-1:0];

  // Saturate the length and drop stray code bits on the way in.
  always_comb begin
    if (in_data.code_length > hpk_pkg::LEN_W'(hpk_pkg::WORD_BITS)) begin
      len_sat = hpk_pkg::LEN_W'(hpk_pkg::WORD_BITS);
    end else begin
      len_sat = in_data.code_length;
    end
    code_clean = in_data.code_bits & hpk_pkg::low_mask(len_sat);
  end

  always_ff @(posedge clk) begin
    if (accept && in_range && (in_data.req_type == hpk_pkg::REQ_LOAD)) begin
      mem[idx] <= {code_clean, len_sat};
    end
    if (accept) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      req_type <= hpk_pkg::REQ_LOAD;
      hit      <= 1'b0;
    end else if (accept) begin
      valid    <= 1'b1;
      req_type <= in_data.req_type;
      hit      <= in_range;
    end else if (advance) begin
      valid    <= 1'b0;
    end
  end

  assign lookup.valid    = valid;
  assign lookup.req_type = req_type;
  assign lookup.hit      = hit;
  assign lookup.code     = rd_data[ENTRY_W-1 -: hpk_pkg::WORD_BITS];
  assign lookup.len      = rd_data[hpk_pkg::LEN_W-1:0];

endmodule

[hdl/hpk_packer.sv]
module hpk_packer (
  input  logic               clk,
  input  logic               rst,
  input  hpk_pkg::lookup_t   lookup,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output hpk_pkg::out_word_t out_data
);

  localparam int W = hpk_pkg::WORD_BITS;

  logic [W-1:0]                accumulator;
  logic [W-1:0]                accumulator_next;
  logic [hpk_pkg::POS_W-1:0]   bit_position;
  logic [hpk_pkg::POS_W-1:0]   bit_position_next;
  logic                        emit;
  hpk_pkg::out_word_t          result;

  logic [2*W-1:0]              wide;
  logic [hpk_pkg::LEN_W:0]     total;
  logic [hpk_pkg::POS_W:0]     round_up;

  assign advance = !out_valid || !out_stall;

  always_comb begin
    wide     = (2*W)'(lookup.code) << bit_position;
    total    = (hpk_pkg::LEN_W+1)'(bit_position) + (hpk_pkg::LEN_W+1)'(lookup.len);
    round_up = (hpk_pkg::POS_W+1)'(bit_position) + (hpk_pkg::POS_W+1)'(7);

    accumulator_next  = accumulator;
    bit_position_next = bit_position;
    emit              = 1'b0;
    result.packed_word = accumulator | wide[W-1:0];
    result.byte_count  = hpk_pkg::FULL_BYTES;
    result.last        = 1'b0;

    case (lookup.req_type)
      hpk_pkg::REQ_ENCODE: begin
        if (lookup.hit) begin
          bit_position_next = total[hpk_pkg::POS_W-1:0];
          if (total < (hpk_pkg::LEN_W+1)'(W)) begin
            accumulator_next = accumulator | wide[W-1:0];
          end else begin
            // word full: overflow bits open the next word
            emit             = 1'b1;
            accumulator_next = wide[2*W-1:W];
          end
        end
      end
      hpk_pkg::REQ_FLUSH: begin
        emit               = 1'b1;
        result.packed_word = accumulator;
        result.byte_count  = round_up[hpk_pkg::POS_W:3];
        result.last        = 1'b1;
        accumulator_next   = '0;
        bit_position_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      bit_position <= '0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= lookup.valid && emit;
      if (lookup.valid) begin
        accumulator  <= accumulator_next;
        bit_position <= bit_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && lookup.valid && emit) begin
      out_data <= result;
    end
  end

endmodule

[hdl/huffman_code_bit_packer.sv]
// A word is registered at the packer output after the item that completes it has passed the table read register.
// Throughput: one item per cycle while no valid output word is held by out_stall; the code table port
// and the packer each take one item a cycle under that condition, and at most one word comes out per item.
// Reset (rst, synchronous): clears the accumulator, bit position and pipeline valids.
// The code table is not cleared; load each symbol before it is encoded.
`include "assert_macros.svh"

module huffman_code_bit_packer #(
  parameter int SYMBOLS = hpk_pkg::SYMBOLS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hpk_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hpk_pkg::out_word_t out_data
);

  // Stage one: table write for loads, registered table read for everything else.
  // Stage two: shift the code to the bit position, OR it into the accumulator
  // and register a word when it fills or a flush arrives.
  hpk_pkg::lookup_t lookup;
  logic             advance;

  // Table lookup. Hold the read data while the packer is stalled.
  hpk_code_mem #(
    .SYMBOLS (SYMBOLS)
  ) u_code_mem (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .lookup   (lookup)
  );

  // Accumulate bits and drive the output register.
  hpk_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .lookup    (lookup),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Back-pressure only ever comes from a full lookup stage.
  `ASSERT_PROP(a_stall_needs_item, clk, rst, in_stall |-> lookup.valid)
  // A word that is not the end of a file is always four full bytes.
  `ASSERT_PROP(a_full_word_bytes, clk, rst, (out_valid && !out_data.last) |-> (out_data.byte_count == hpk_pkg::FULL_BYTES))
  // An empty flush carries no bits.
  `ASSERT_PROP(a_empty_flush, clk, rst, (out_valid && out_data.last && (out_data.byte_count == 3'd0)) |-> (out_data.packed_word == '0))

endmodule
